// ===== design/bpc_pkg.sv =====
`default_nettype none
package bpc_pkg;

  localparam int DivStages = 64;
  localparam int QueueDepth = 2;
  localparam int QueueAw = $clog2(QueueDepth);

  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] PresBase = 64'd1048576;
  localparam logic [63:0] PresScale = 64'd3125;
  localparam logic [63:0] OneQ47 = 64'h0000_8000_0000_0000;

  typedef enum logic [2:0] {
    REG_T1_T2 = 3'd0,
    REG_T3    = 3'd1,
    REG_P1_P2 = 3'd2,
    REG_P3_P4 = 3'd3,
    REG_P5_P6 = 3'd4,
    REG_P7_P8 = 3'd5,
    REG_P9    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        pressure_q24_8;
    logic signed [31:0] fine_temperature;
    logic               zero_divisor;
  } out_item_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [31:0] fine_temperature;
  } mid_t;

  typedef struct packed {
    logic [31:0] fine_temperature;
    logic        zero_divisor;
  } side_t;

  function automatic logic [63:0] sx64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== design/bpc_front.sv =====
`default_nettype none
module bpc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bpc_pkg::in_item_t in_data_i,
  input  bpc_pkg::cal_t   cal_i,
  output logic            mid_valid_o,
  output bpc_pkg::mid_t   mid_data_o,
  input  logic            mid_full_i
);
  import bpc_pkg::*;

  logic [3:0]  v_q;
  logic        en;
  logic [19:0] ap1_q, ap2_q, ap3_q, ap4_q;
  logic [31:0] d1_d, d2_d, d1_q, d2_q;
  logic [31:0] m1_q, m2_q;
  logic [31:0] tv1_q, m3_q;
  logic [31:0] m2s, tfine_d, tfine_q;

  assign en = !(v_q[3] && mid_full_i);
  assign in_stall_o = !en;

  always_comb begin
    d1_d = 32'(in_data_i.raw_temperature[19:3]) - {15'd0, cal_i.t1, 1'b0};
    d2_d = 32'(in_data_i.raw_temperature[19:4]) - {16'd0, cal_i.t1};
    m2s = 32'($signed(m2_q) >>> 12);
    tfine_d = tv1_q + 32'($signed(m3_q) >>> 14);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ap1_q   <= in_data_i.raw_pressure;
      d1_q    <= d1_d;
      d2_q    <= d2_d;
      ap2_q   <= ap1_q;
      m1_q    <= d1_q * sx32(cal_i.t2);
      m2_q    <= d2_q * d2_q;
      ap3_q   <= ap2_q;
      tv1_q   <= 32'($signed(m1_q) >>> 11);
      m3_q    <= m2s * sx32(cal_i.t3);
      ap4_q   <= ap3_q;
      tfine_q <= tfine_d;
    end
  end

  assign mid_valid_o = v_q[3];
  assign mid_data_o  = '{raw_pressure: ap4_q, fine_temperature: tfine_q};

endmodule
`default_nettype wire

// ===== design/bpc_queue.sv =====
`default_nettype none
module bpc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bpc_pkg::mid_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bpc_pkg::mid_t data_o
);
  import bpc_pkg::*;

  mid_t                 mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_q, rd_q;
  logic [QueueAw:0]     cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (QueueAw+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QueueAw+1)'(do_push) - (QueueAw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/bpc_div.sv =====
`default_nettype none
module bpc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [63:0]    num_i,
  input  logic [63:0]    den_i,
  input  bpc_pkg::side_t side_i,
  output logic           valid_o,
  output logic [63:0]    quo_o,
  output bpc_pkg::side_t side_o
);
  import bpc_pkg::*;

  logic [DivStages:0] v_q;
  logic [63:0]        rem_q  [DivStages+1];
  logic [63:0]        acc_q  [DivStages+1];
  logic [63:0]        den_q  [DivStages+1];
  logic               neg_q  [DivStages+1];
  side_t              side_q [DivStages+1];
  logic               out_v_q;
  logic [63:0]        quo_q;
  side_t              out_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[DivStages-1:0], valid_i};
      out_v_q <= v_q[DivStages];
    end
  end

  // take magnitudes, restore the sign at the end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      acc_q[0]  <= num_i[63] ? (64'd0 - num_i) : num_i;
      den_q[0]  <= den_i[63] ? (64'd0 - den_i) : den_i;
      neg_q[0]  <= num_i[63] ^ den_i[63];
      side_q[0] <= side_i;
      quo_q      <= neg_q[DivStages] ? (64'd0 - acc_q[DivStages]) : acc_q[DivStages];
      out_side_q <= side_q[DivStages];
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_q[k], acc_q[k][63]};
      diff  = trial - {1'b0, den_q[k]};
      ge    = (trial >= {1'b0, den_q[k]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[63:0] : trial[63:0];
        acc_q[k+1]  <= {acc_q[k][62:0], ge};
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = out_v_q;
  assign quo_o   = quo_q;
  assign side_o  = out_side_q;

endmodule
`default_nettype wire

// ===== design/bpc_back.sv =====
`default_nettype none
module bpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpc_pkg::cal_t      cal_i,
  input  logic               q_valid_i,
  input  bpc_pkg::mid_t      q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bpc_pkg::out_item_t out_data_o
);
  import bpc_pkg::*;

  logic        en;
  logic [5:0]  bv_q;
  logic [4:0]  pv_q;
  logic        out_v_q;
  out_item_t   out_q;

  logic [19:0] ap0_q, ap1_q, ap2_q, ap3_q;
  logic [31:0] tf0_q, tf1_q, tf2_q, tf3_q, tf4_q, tf5_q;
  logic [63:0] x_q;
  logic [63:0] xx_q, xp5_q, xp2_q;
  logic [63:0] v2a_q, v1a_q, xp5b_q, xp2b_q;
  logic [63:0] v2_q, t_q;
  logic [63:0] v1_q, pd_q;
  logic [63:0] num_q, den_q;
  logic        z_q;
  logic [63:0] tprod;

  logic        dv;
  logic [63:0] quo;
  side_t       dside;
  side_t       ps1_q, ps2_q, ps3_q, ps4_q, ps5_q;
  logic [63:0] p1_q, p2_q, p3_q;
  logic [63:0] q1_q;
  logic [63:0] a1_q, b1_q, b2_q, b3_q;
  logic [63:0] ll_q, lh_q, hl_q;
  logic [63:0] aqq_q, s_q, r_q;
  logic [31:0] sat;

  assign en      = !(out_v_q && out_stall_i);
  assign q_pop_o = en && q_valid_i;
  assign tprod   = t_q * {48'd0, cal_i.p1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q    <= '0;
      pv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      bv_q    <= {bv_q[4:0], q_valid_i};
      pv_q    <= {pv_q[3:0], dv};
      out_v_q <= pv_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ap0_q  <= q_data_i.raw_pressure;
      tf0_q  <= q_data_i.fine_temperature;
      x_q    <= {{32{q_data_i.fine_temperature[31]}}, q_data_i.fine_temperature}
                - FineOffset;
      ap1_q  <= ap0_q;
      tf1_q  <= tf0_q;
      xx_q   <= x_q * x_q;
      xp5_q  <= x_q * sx64(cal_i.p5);
      xp2_q  <= x_q * sx64(cal_i.p2);
      ap2_q  <= ap1_q;
      tf2_q  <= tf1_q;
      v2a_q  <= xx_q * sx64(cal_i.p6);
      v1a_q  <= xx_q * sx64(cal_i.p3);
      xp5b_q <= xp5_q;
      xp2b_q <= xp2_q;
      ap3_q  <= ap2_q;
      tf3_q  <= tf2_q;
      v2_q   <= v2a_q + (xp5b_q << 17) + (sx64(cal_i.p4) << 35);
      t_q    <= OneQ47 + 64'($signed(v1a_q) >>> 8) + (xp2b_q << 12);
      tf4_q  <= tf3_q;
      v1_q   <= 64'($signed(tprod) >>> 33);
      pd_q   <= ((PresBase - {44'd0, ap3_q}) << 31) - v2_q;
      tf5_q  <= tf4_q;
      num_q  <= pd_q * PresScale;
      den_q  <= v1_q;
      z_q    <= (v1_q == '0);
    end
  end

  bpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (bv_q[5]),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  ('{fine_temperature: tf5_q, zero_divisor: z_q}),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (dside)
  );

  always_comb begin
    if (r_q[63]) begin
      sat = '0;
    end else if (|r_q[62:32]) begin
      sat = '1;
    end else begin
      sat = r_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps1_q <= dside;
      p1_q  <= quo;
      q1_q  <= 64'($signed(quo) >>> 13);
      a1_q  <= sx64(cal_i.p9) * 64'($signed(quo) >>> 13);
      b1_q  <= sx64(cal_i.p8) * quo;
      ps2_q <= ps1_q;
      p2_q  <= p1_q;
      b2_q  <= b1_q;
      ll_q  <= a1_q[31:0] * q1_q[31:0];
      lh_q  <= {32'd0, 32'(a1_q[31:0] * q1_q[63:32])};
      hl_q  <= {32'd0, 32'(a1_q[63:32] * q1_q[31:0])};
      ps3_q <= ps2_q;
      p3_q  <= p2_q;
      b3_q  <= b2_q;
      aqq_q <= ll_q + {32'(lh_q[31:0] + hl_q[31:0]), 32'd0};
      ps4_q <= ps3_q;
      s_q   <= p3_q + 64'($signed(aqq_q) >>> 25) + 64'($signed(b3_q) >>> 19);
      ps5_q <= ps4_q;
      r_q   <= 64'($signed(s_q) >>> 8) + (sx64(cal_i.p7) << 4);
      out_q.pressure_q24_8   <= ps5_q.zero_divisor ? 32'd0 : sat;
      out_q.fine_temperature <= ps5_q.fine_temperature;
      out_q.zero_divisor     <= ps5_q.zero_divisor;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== design/baro_pressure_compensation_core.sv =====
`default_nettype none
// channel   direction  handshake             payload
// in        input      in_valid_i/in_stall_o   in_item_t (raw pressure, raw temperature)
// out       output     out_valid_o/out_stall_i out_item_t (pressure, fine temp, flag)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per cycle while the output is not stalled; the latency is set by the
// 64-step pipelined divider plus the temperature and pressure multiply stages.
// Reset clears all calibration registers and every valid bit.
// An output stall holds the back pipeline; the two-entry queue lets the
// temperature front keep accepting until it fills.
module baro_pressure_compensation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bpc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bpc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import bpc_pkg::*;

  logic [31:0] r_t1t2_q, r_p1p2_q, r_p3p4_q, r_p5p6_q, r_p7p8_q;
  logic [15:0] r_t3_q, r_p9_q;
  cal_t        cal;
  logic        mid_valid, mid_full, q_valid, q_pop;
  mid_t        mid_data, q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_t1t2_q <= '0;
      r_t3_q   <= '0;
      r_p1p2_q <= '0;
      r_p3p4_q <= '0;
      r_p5p6_q <= '0;
      r_p7p8_q <= '0;
      r_p9_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_T1_T2: r_t1t2_q <= cfg_data_i;
        REG_T3:    r_t3_q   <= cfg_data_i[15:0];
        REG_P1_P2: r_p1p2_q <= cfg_data_i;
        REG_P3_P4: r_p3p4_q <= cfg_data_i;
        REG_P5_P6: r_p5p6_q <= cfg_data_i;
        REG_P7_P8: r_p7p8_q <= cfg_data_i;
        REG_P9:    r_p9_q   <= cfg_data_i[15:0];
        default:   ;
      endcase
    end
  end

  assign cal = '{t1: r_t1t2_q[15:0], t2: r_t1t2_q[31:16], t3: r_t3_q,
                 p1: r_p1p2_q[15:0], p2: r_p1p2_q[31:16],
                 p3: r_p3p4_q[15:0], p4: r_p3p4_q[31:16],
                 p5: r_p5p6_q[15:0], p6: r_p5p6_q[31:16],
                 p7: r_p7p8_q[15:0], p8: r_p7p8_q[31:16], p9: r_p9_q};

  bpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cal_i       (cal),
    .mid_valid_o (mid_valid),
    .mid_data_o  (mid_data),
    .mid_full_i  (mid_full)
  );

  bpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_valid),
    .data_i  (mid_data),
    .full_o  (mid_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  bpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_baro_pressure_compensation_core.sv =====
`default_nettype none
module tb_baro_pressure_compensation_core;
  import bpc_pkg::*;

  localparam logic [2:0] UnusedIdx = 3'd7;
  localparam int DrainCycles = 120;
  localparam int StallLimit = 20000;
  localparam int HoldOffCycles = 400;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  logic [31:0] cal_regs [7];
  out_item_t   pending_results [$];
  int          error_cnt;
  int          sent_cnt;
  int          checked_cnt;
  int          zero_div_cnt;
  int          sat_cnt;
  int          progress_cnt;
  bit          idle_on;
  bit          hold_req;

  baro_pressure_compensation_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = n[63] ? 64'd0 - n : n;
    md = d[63] ? 64'd0 - d : d;
    q = mn / md;
    return (n[63] != d[63]) ? 64'd0 - q : q;
  endfunction

  function automatic out_item_t compensate(input in_item_t it);
    logic [31:0] at, t1, t2, t3, d1, d2, tv1, tv2, tf;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] x, v1, v2, p, q;
    out_item_t r;
    at = {12'd0, it.raw_temperature};
    t1 = {16'd0, cal_regs[0][15:0]};
    t2 = sext16(cal_regs[0][31:16]);
    t3 = sext16(cal_regs[1][15:0]);
    p1 = {48'd0, cal_regs[2][15:0]};
    p2 = sext16(cal_regs[2][31:16]);
    p3 = sext16(cal_regs[3][15:0]);
    p4 = sext16(cal_regs[3][31:16]);
    p5 = sext16(cal_regs[4][15:0]);
    p6 = sext16(cal_regs[4][31:16]);
    p7 = sext16(cal_regs[5][15:0]);
    p8 = sext16(cal_regs[5][31:16]);
    p9 = sext16(cal_regs[6][15:0]);
    d1 = (at >> 3) - (t1 << 1);
    tv1 = asr32(d1 * t2, 11);
    d2 = (at >> 4) - t1;
    tv2 = asr32(asr32(d2 * d2, 12) * t3, 14);
    tf = tv1 + tv2;
    x = {{32{tf[31]}}, tf} - 64'd128000;
    v2 = x * x * p6;
    v2 = v2 + ((x * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(x * x * p3, 8) + ((x * p2) << 12);
    v1 = asr64((64'h0000_8000_0000_0000 + v1) * p1, 33);
    r.fine_temperature = tf;
    r.pressure_q24_8 = 32'd0;
    r.zero_divisor = (v1 == 64'd0);
    if (v1 != 64'd0) begin
      p = 64'd1048576 - {44'd0, it.raw_pressure};
      p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
      q = asr64(p, 13);
      v1 = asr64(p9 * q * q, 25);
      v2 = asr64(p8 * p, 19);
      p = asr64(p + v1 + v2, 8) + (p7 << 4);
      if (p[63]) r.pressure_q24_8 = 32'd0;
      else if (p > 64'hFFFF_FFFF) r.pressure_q24_8 = 32'hFFFF_FFFF;
      else r.pressure_q24_8 = p[31:0];
    end
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    progress_cnt++;
    if (idx == REG_T3 || idx == REG_P9) cal_regs[idx] = {16'd0, data[15:0]};
    else if (idx != UnusedIdx) cal_regs[idx] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_cal(input logic [31:0] t12, t3, p12, p34, p56, p78, p9);
    write_reg(REG_T1_T2, t12);
    write_reg(REG_T3, t3);
    write_reg(REG_P1_P2, p12);
    write_reg(REG_P3_P4, p34);
    write_reg(REG_P5_P6, p56);
    write_reg(REG_P7_P8, p78);
    write_reg(REG_P9, p9);
  endtask

  // Leaves the caller at a falling edge with valid still high.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t result);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(typed ? result : compensate(it));
    sent_cnt++;
    progress_cnt++;
    @(negedge clk_i);
  endtask

  // Called at a falling edge: drop valid before the next rising edge.
  task automatic drain;
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_item_t random_reading;
    in_item_t it;
    if ($urandom_range(0, 3) == 0) begin
      it.raw_pressure = 20'($urandom);
      it.raw_temperature = 20'($urandom);
    end else begin
      it.raw_pressure = 20'($urandom_range(200000, 500000));
      it.raw_temperature = 20'($urandom_range(400000, 600000));
    end
    return it;
  endfunction

  // Datasheet-like calibration, optionally jittered.
  task automatic load_typical(input bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 511)) - 16'd256 : 16'd0;
    load_cal({16'd26435 + j, 16'd27504 + j}, 32'(-16'sd1000) + j,
             {-16'sd10685 + j, 16'd36477 + j}, {16'd2855 + j, 16'd3024 + j},
             {-16'sd7, 16'd140 + j}, {-16'sd14600 + j, 16'd15500 + j}, 32'd6000 + j);
  endtask

  task automatic run_random(input int n);
    out_item_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      send_item(random_reading(), 1'b0, none);
    end
  endtask

  // Result checker and receiver-side stalls.
  initial begin
    int wait_left;
    out_item_t exp;
    out_stall_i = 1'b0;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        progress_cnt++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          error_cnt++;
        end else begin
          exp = pending_results.pop_front();
          checked_cnt++;
          if (exp.zero_divisor) zero_div_cnt++;
          if (exp.pressure_q24_8 == 32'hFFFF_FFFF) sat_cnt++;
          if (out_data_o.pressure_q24_8 !== exp.pressure_q24_8) begin
            $display("%0t: pressure exp %h act %h", $time,
                     exp.pressure_q24_8, out_data_o.pressure_q24_8);
            error_cnt++;
          end
          if (out_data_o.fine_temperature !== exp.fine_temperature) begin
            $display("%0t: fine temp exp %h act %h", $time,
                     exp.fine_temperature, out_data_o.fine_temperature);
            error_cnt++;
          end
          if (out_data_o.zero_divisor !== exp.zero_divisor) begin
            $display("%0t: zero divisor exp %b act %b", $time,
                     exp.zero_divisor, out_data_o.zero_divisor);
            error_cnt++;
          end
        end
        wait_left = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (hold_req) begin
        wait_left = HoldOffCycles;
        hold_req = 1'b0;
      end
      @(negedge clk_i);
      out_stall_i <= (wait_left > 0);
      if (wait_left > 0) wait_left--;
    end
  end

  initial begin
    int quiet;
    int last;
    quiet = 0;
    last = 0;
    forever begin
      @(negedge clk_i);
      if (progress_cnt != last) quiet = 0;
      else quiet++;
      last = progress_cnt;
      if (quiet >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t r;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_T1_T2;
    cfg_data_i = '0;
    error_cnt = 0;
    sent_cnt = 0;
    checked_cnt = 0;
    zero_div_cnt = 0;
    sat_cnt = 0;
    progress_cnt = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    for (int i = 0; i < 7; i++) cal_regs[i] = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Cleared calibration: P1 is zero, so every reading hits the zero divisor.
    r.typed = 1'b1;
    r.result = '{pressure_q24_8: 32'd0, fine_temperature: 32'sd0, zero_divisor: 1'b1};
    r.item = '{20'd0, 20'd0};             rows.push_back(r);
    r.item = '{20'hFFFFF, 20'hFFFFF};     rows.push_back(r);
    r.item = '{20'd0, 20'hFFFFF};         rows.push_back(r);
    r.item = '{20'hFFFFF, 20'd0};         rows.push_back(r);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);
    drain();

    load_typical(1'b0);
    write_reg(UnusedIdx, 32'hDEAD_BEEF);
    rows.delete();
    r.typed = 1'b0;
    r.item = '{20'd415148, 20'd519888};   rows.push_back(r);
    r.item = '{20'd0, 20'd519888};        rows.push_back(r);
    r.item = '{20'hFFFFF, 20'd519888};    rows.push_back(r);
    r.item = '{20'd415148, 20'd0};        rows.push_back(r);
    r.item = '{20'd415148, 20'hFFFFF};    rows.push_back(r);
    r.item = '{20'hFFFFF, 20'hFFFFF};     rows.push_back(r);
    r.item = '{20'd0, 20'd0};             rows.push_back(r);
    r.item = '{20'h55555, 20'hAAAAA};     rows.push_back(r);
    r.item = '{20'hAAAAA, 20'h55555};     rows.push_back(r);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);
    drain();

    // Extreme calibration words: all ones, then signed maxima and minima.
    load_cal('1, '1, '1, '1, '1, '1, '1);
    run_random(100);
    drain();
    load_cal(32'h7FFF_FFFF, 32'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
             32'h7FFF_7FFF, 32'h7FFF);
    run_random(100);
    drain();
    load_cal(32'h8000_0000, 32'h8000, 32'h8000_0001, 32'h8000_8000, 32'h8000_8000,
             32'h8000_8000, 32'h8000);
    run_random(100);
    drain();

    // Receiver holds off long enough for the pipeline to back up.
    load_typical(1'b1);
    hold_req = 1'b1;
    run_random(250);
    drain();

    load_typical(1'b1);
    run_random(150);
    // Sender stops until every result is back, then resumes.
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);
    run_random(150);
    drain();

    // Back-to-back stretch on both sides.
    idle_on = 1'b0;
    load_typical(1'b1);
    run_random(200);
    drain();
    idle_on = 1'b1;

    for (int k = 0; k < 3; k++) begin
      load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(100);
      drain();
    end

    $display("Sent %0d readings, checked %0d results (%0d zero divisor, %0d saturated)",
             sent_cnt, checked_cnt, zero_div_cnt, sat_cnt);
    $display("Covered cleared, datasheet-like, extreme and random calibration sets");
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
